@@ rtl/fbm_pkg.sv @@
// ============================================================================
// fbm_pkg : shared types, constants and functions of the 1-D fractal noise unit
// Holds the register indexes, hash multipliers and the per-octave reciprocal
// table used to normalize the weighted octave sum.
// ============================================================================
package fbm_pkg;

    localparam int MAX_OCTAVES_DEF = 8;
    localparam int FRAC_BITS_DEF   = 16;

    localparam logic [1:0] REG_NOISE_SEED     = 2'd0;
    localparam logic [1:0] REG_BASE_FREQUENCY = 2'd1;
    localparam logic [1:0] REG_OCTAVE_COUNT   = 2'd2;

    localparam logic [31:0] HASH_MUL_IDX  = 32'h9E3779B1;
    localparam logic [31:0] HASH_MUL_SEED = 32'h85EBCA6B;
    localparam logic [31:0] HASH_MUL_A    = 32'h2C1B3C6D;
    localparam logic [31:0] HASH_MUL_B    = 32'h297A2D39;
    localparam logic [31:0] SEED_STEP     = 32'h00009E37;

    // Per-octave seed term, seed * HASH_MUL_SEED for seed = base + o*step.
    // Linear in seed: base*M + o*(step*M), all mod 2^32.
    localparam logic [31:0] SEED_STEP_MUL = SEED_STEP * HASH_MUL_SEED;

    // Reciprocal for division by (2^k - 1) * 65536 with k octaves:
    // q = ((sum >> 16) * RECIP) >> RECIP_SHIFT, then at most one +1 correction.
    localparam int RECIP_SHIFT = 34;

    // floor(2^34 / (2^k - 1))
    function automatic logic [34:0] recip_of(input logic [4:0] k);
        begin
            case (k)
                5'd1:    recip_of = 35'd17179869184;
                5'd2:    recip_of = 35'd5726623061;
                5'd3:    recip_of = 35'd2454267026;
                5'd4:    recip_of = 35'd1145324612;
                5'd5:    recip_of = 35'd554189328;
                5'd6:    recip_of = 35'd272696336;
                5'd7:    recip_of = 35'd135274560;
                5'd8:    recip_of = 35'd67372036;
                5'd9:    recip_of = 35'd33620096;
                5'd10:   recip_of = 35'd16793616;
                5'd11:   recip_of = 35'd8392706;
                5'd12:   recip_of = 35'd4195328;
                5'd13:   recip_of = 35'd2097408;
                5'd14:   recip_of = 35'd1048640;
                5'd15:   recip_of = 35'd524304;
                5'd16:   recip_of = 35'd262148;
                default: recip_of = 35'd17179869184;
            endcase
        end
    endfunction

endpackage

@@ rtl/fbm_value_noise_1d_unit.sv @@
// ============================================================================
// fbm_value_noise_1d_unit : 1-D fractal value noise, one sample per cycle if not stalled
// Position times frequency, parallel octave lanes, normalization pipeline.
// ============================================================================
// channel   dir  handshake           payload
// in        in   in_valid/in_ready   x_position[31:0] signed Q16.16
// out       out  out_valid/out_ready noise_value[15:0] Q0.16
// cfg       in   cfg_we              cfg_index[1:0], cfg_data[31:0]
//
// Pipeline of 2 product, 4 octave lane and 5 normalize stages from input
// transfer to out_valid; one transfer per cycle sustained while the output is
// taken; octave lanes run in parallel so the octave count does not change rate.
// The pipeline advances as a whole when the output stage is empty or taken.
// Reset clears valid bits and loads register defaults.
module fbm_value_noise_1d_unit #(
    parameter int MAX_OCTAVES = fbm_pkg::MAX_OCTAVES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] x_position,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] noise_value,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int DEPTH = 11;

    logic [31:0] noise_seed_reg;
    logic [23:0] base_frequency_reg;
    logic [3:0]  octave_count_reg;
    logic [DEPTH-1:0] vld_reg;
    logic        adv;
    logic [55:0] plo_reg, phi_reg;
    logic [63:0] prod_w;
    logic [31:0] seed_mul_reg;
    logic [4:0]  k_w;
    logic [4:0]  k_pipe_reg [0:5];
    logic [MAX_OCTAVES-1:0][31:0] idx_w, blend_w;
    logic [MAX_OCTAVES-1:0][15:0] frac_w;
    logic [63:0] prod_reg;

    assign adv      = !vld_reg[DEPTH-1] || out_ready;
    assign in_ready = adv;
    assign out_valid = vld_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_seed_reg     <= 32'd0;
            base_frequency_reg <= 24'd65536;
            octave_count_reg   <= 4'd1;
            vld_reg            <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    fbm_pkg::REG_NOISE_SEED:     noise_seed_reg     <= cfg_data;
                    fbm_pkg::REG_BASE_FREQUENCY: base_frequency_reg <= cfg_data[23:0];
                    fbm_pkg::REG_OCTAVE_COUNT:   octave_count_reg   <= cfg_data[3:0];
                    default: ;
                endcase
            end
            if (adv)
                vld_reg <= {vld_reg[DEPTH-2:0], in_valid};
        end
    end

    always_comb
    begin
        if (octave_count_reg == 4'd0)
            k_w = 5'd1;
        else if (int'(octave_count_reg) > MAX_OCTAVES)
            k_w = 5'(MAX_OCTAVES);
        else
            k_w = {1'b0, octave_count_reg};
    end

    // stage 0: signed 32x24 product in two halves; stage 1: sum
    assign prod_w = {{8{plo_reg[55]}}, plo_reg} + ({{8{phi_reg[55]}}, phi_reg} << 12);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            plo_reg <= 56'($signed(x_position) * $signed({1'b0, base_frequency_reg[11:0]}));
            phi_reg <= 56'($signed(x_position) * $signed({1'b0, base_frequency_reg[23:12]}));
            prod_reg <= prod_w;
            seed_mul_reg <= noise_seed_reg * fbm_pkg::HASH_MUL_SEED;
            k_pipe_reg[0] <= k_w;
            for (int i = 1; i < 6; i++)
                k_pipe_reg[i] <= k_pipe_reg[i-1];
        end
    end

    genvar g;
    generate
        for (g = 0; g < MAX_OCTAVES; g++)
        begin : g_oct
            logic [63:0] sc;
            assign sc = prod_reg << g;
            assign idx_w[g]  = sc[63:32];
            assign frac_w[g] = sc[31:16];
            fbm_octave #(.OCT(g)) u_oct (
                .clk(clk), .en(adv), .idx(idx_w[g]), .frac(frac_w[g]),
                .seed_mul(seed_mul_reg), .blend(blend_w[g])
            );
        end
    endgenerate

    fbm_norm #(.MAX_OCTAVES(MAX_OCTAVES)) u_norm (
        .clk(clk), .en(adv), .blend(blend_w), .k(k_pipe_reg[5]),
        .noise_value(noise_value)
    );

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(noise_value))
        else $error("output changed under stall");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready) else $error("ready low with empty output");
    a_adv: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg)) else $error("pipeline moved under stall");

endmodule

@@ rtl/fbm_octave.sv @@
// ============================================================================
// fbm_octave : one octave lane, hash of two lattice points and smoothstep blend
// Pipelined over four register stages; one multiply between registers.
// ============================================================================
module fbm_octave #(
    parameter int OCT = 0
) (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] idx,
    input  logic [15:0] frac,
    input  logic [31:0] seed_mul,
    output logic [31:0] blend
);

    // stage 1: idx * M, t*t
    logic [31:0] ha1_reg, hb1_reg, sm1_reg;
    logic [31:0] tt1_reg;
    logic [15:0] t1_reg;
    // stage 2: xorshift, mul A; s term
    logic [31:0] ha2_reg, hb2_reg;
    logic [33:0] s2_reg;
    // stage 3: mul B
    logic [31:0] ha3_reg, hb3_reg;
    logic [16:0] s3_reg;
    // stage 4: final and blend products
    logic [31:0] bl4_reg;

    logic [31:0] ha_x, hb_x, ha_y, hb_y, ha_z, hb_z;
    logic [15:0] t2_w;
    logic [17:0] w_w;
    logic [16:0] s_w;
    logic [15:0] a_w, b_w;

    always_comb
    begin
        ha_x = ha1_reg ^ sm1_reg;
        hb_x = hb1_reg ^ sm1_reg;
        ha_x = ha_x ^ (ha_x >> 15);
        hb_x = hb_x ^ (hb_x >> 15);
        t2_w = tt1_reg[31:16];
        w_w  = 18'd196608 - {1'b0, t1_reg, 1'b0};
        ha_y = ha2_reg ^ (ha2_reg >> 12);
        hb_y = hb2_reg ^ (hb2_reg >> 12);
        s_w  = (s2_reg[33:16] > 18'd65536) ? 17'd65536 : s2_reg[32:16];
        ha_z = ha3_reg ^ (ha3_reg >> 15);
        hb_z = hb3_reg ^ (hb3_reg >> 15);
        a_w  = ha_z[31:16];
        b_w  = hb_z[31:16];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ha1_reg <= idx * fbm_pkg::HASH_MUL_IDX;
            hb1_reg <= (idx + 32'd1) * fbm_pkg::HASH_MUL_IDX;
            sm1_reg <= seed_mul + 32'(OCT) * fbm_pkg::SEED_STEP_MUL;
            tt1_reg <= {16'd0, frac} * {16'd0, frac};
            t1_reg  <= frac;
            ha2_reg <= ha_x * fbm_pkg::HASH_MUL_A;
            hb2_reg <= hb_x * fbm_pkg::HASH_MUL_A;
            s2_reg  <= 34'({18'd0, t2_w} * {16'd0, w_w});
            ha3_reg <= ha_y * fbm_pkg::HASH_MUL_B;
            hb3_reg <= hb_y * fbm_pkg::HASH_MUL_B;
            s3_reg  <= s_w;
            bl4_reg <= 32'({16'd0, a_w} * (33'd65536 - {16'd0, s3_reg})
                     + {17'd0, b_w} * {16'd0, s3_reg});
        end
    end

    assign blend = bl4_reg;

endmodule

@@ rtl/fbm_norm.sv @@
// ============================================================================
// fbm_norm : weighted octave sum and normalization by the total amplitude
// Registered adder tree, reciprocal multiply split in two halves, correction.
// ============================================================================
module fbm_norm #(
    parameter int MAX_OCTAVES = fbm_pkg::MAX_OCTAVES_DEF
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic [MAX_OCTAVES-1:0][31:0]  blend,
    input  logic [4:0]                    k,
    output logic [15:0]                   noise_value
);

    localparam int SW = 32 + MAX_OCTAVES;
    localparam int QW = SW - 16;

    logic [SW-1:0]   sum1_reg;
    logic [4:0]      k1_reg, k2_reg, k3_reg;
    logic [SW-1:0]   sum2_reg, sum3_reg;
    logic [34:0]     rc2_reg;
    logic [QW+16:0]  plo3_reg;
    logic [QW+17:0]  phi3_reg;
    logic [SW-1:0]   q4_reg;
    logic [SW-1:0]   sum4_reg;
    logic [4:0]      k4_reg;
    logic [15:0]     out_reg;

    logic [SW-1:0]   acc_w;
    logic [QW+34:0]  prod_w;
    logic [SW-1:0]   q_w;
    logic [SW+16:0]  den_w, rem_w, qd_w;

    always_comb
    begin
        acc_w = '0;
        for (int o = 0; o < MAX_OCTAVES; o++)
            if (o < int'(k))
                acc_w = acc_w + (SW'(blend[o]) << (int'(k) - 1 - o));
    end

    // quotient estimate is exact or one low; the remainder check fixes it
    always_comb
    begin
        prod_w = {18'd0, plo3_reg} + ({17'd0, phi3_reg} << 17);
        q_w    = SW'(prod_w >> fbm_pkg::RECIP_SHIFT);
        den_w  = ((SW+17)'(1) << k4_reg) - (SW+17)'(1);
        den_w  = den_w << 16;
        qd_w   = ((SW+17)'(q4_reg) << k4_reg) - (SW+17)'(q4_reg);
        rem_w  = (SW+17)'(sum4_reg) - (qd_w << 16);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum1_reg <= acc_w;
            k1_reg   <= k;
            sum2_reg <= sum1_reg;
            k2_reg   <= k1_reg;
            rc2_reg  <= fbm_pkg::recip_of(k1_reg);
            sum3_reg <= sum2_reg;
            k3_reg   <= k2_reg;
            plo3_reg <= {17'd0, sum2_reg[SW-1:16]} * {{QW{1'b0}}, rc2_reg[16:0]};
            phi3_reg <= {18'd0, sum2_reg[SW-1:16]} * {{QW{1'b0}}, rc2_reg[34:17]};
            q4_reg   <= q_w;
            sum4_reg <= sum3_reg;
            k4_reg   <= k3_reg;
            if (rem_w >= den_w)
                out_reg <= ((q4_reg + SW'(1)) > SW'(65535)) ? 16'hFFFF
                         : 16'(q4_reg + SW'(1));
            else
                out_reg <= (q4_reg > SW'(65535)) ? 16'hFFFF : 16'(q4_reg);
        end
    end

    assign noise_value = out_reg;

endmodule
